### hw/rtl/kbf_pkg.sv
// Shared types, constants and the control store of the keyboard report framer.
package kbf_pkg;

  localparam int MAX_KEYS_DEF  = 6;
  localparam int KEY_SLOTS_DEF = 7;
  localparam int MOD_KEYS      = 6;
  localparam int CFG_AW        = 5;
  localparam int CFG_DW        = 32;

  localparam logic [7:0] BYTE_SOH   = 8'h01;
  localparam logic [7:0] BYTE_STX   = 8'h02;
  localparam logic [7:0] BYTE_ETX   = 8'h03;
  localparam logic [7:0] BYTE_EOT   = 8'h04;
  localparam logic [7:0] SUM_WEIGHT = 8'd211;

  // modifier bit per code register, left_ctrl first; later entries win a tie
  localparam logic [2:0] MOD_BIT [MOD_KEYS] = '{3'd0, 3'd1, 3'd2, 3'd4, 3'd5, 3'd6};

  localparam logic [7:0] MOD_CODE_RST [MOD_KEYS] =
    '{8'd224, 8'd225, 8'd226, 8'd228, 8'd229, 8'd230};

  typedef enum logic [2:0] {
    REG_LEFT_CTRL   = 3'd0,
    REG_LEFT_SHIFT  = 3'd1,
    REG_LEFT_ALT    = 3'd2,
    REG_RIGHT_CTRL  = 3'd3,
    REG_RIGHT_SHIFT = 3'd4,
    REG_RIGHT_ALT   = 3'd5,
    REG_FRAME_TYPE  = 3'd6,
    REG_NONE        = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [MOD_KEYS-1:0][7:0] mod_code;
    logic [7:0]               frame_type;
  } cfg_t;

  typedef logic [3:0] step_t;

  typedef enum logic [3:0] {
    SRC_SOH,
    SRC_STX,
    SRC_TYPE,
    SRC_LEN,
    SRC_MOD,
    SRC_KEY,
    SRC_SUM,
    SRC_ETX,
    SRC_EOT
  } src_t;

  typedef enum logic [1:0] {
    SUM_HOLD,
    SUM_INIT,
    SUM_ADD
  } sum_op_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_ALWAYS,
    JMP_SLOT_MORE
  } jmp_t;

  typedef struct packed {
    logic    take;
    logic    emit;
    logic    last;
    src_t    src;
    sum_op_t sum_op;
    logic    slot_inc;
    jmp_t    jmp;
    step_t   target;
  } ucode_t;

  typedef struct packed {
    ucode_t uw;
    logic   go;
  } ctl_t;

  typedef struct packed {
    logic out_free;
    logic slot_last;
  } stat_t;

  localparam step_t STEP_TAKE = 4'd0;
  localparam step_t STEP_KEY  = 4'd6;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    w = '0;
    case (step)
      4'd0: begin
        w.take = 1'b1;
      end
      4'd1: begin
        w.emit = 1'b1;
        w.src  = SRC_SOH;
      end
      4'd2: begin
        w.emit = 1'b1;
        w.src  = SRC_STX;
      end
      4'd3: begin
        w.emit = 1'b1;
        w.src  = SRC_TYPE;
      end
      4'd4: begin
        w.emit = 1'b1;
        w.src  = SRC_LEN;
      end
      4'd5: begin
        w.emit   = 1'b1;
        w.src    = SRC_MOD;
        w.sum_op = SUM_INIT;
      end
      4'd6: begin
        w.emit     = 1'b1;
        w.src      = SRC_KEY;
        w.sum_op   = SUM_ADD;
        w.slot_inc = 1'b1;
        w.jmp      = JMP_SLOT_MORE;
        w.target   = STEP_KEY;
      end
      4'd7: begin
        w.emit = 1'b1;
        w.src  = SRC_SUM;
      end
      4'd8: begin
        w.emit = 1'b1;
        w.src  = SRC_ETX;
      end
      4'd9: begin
        w.emit   = 1'b1;
        w.last   = 1'b1;
        w.src    = SRC_EOT;
        w.jmp    = JMP_ALWAYS;
        w.target = STEP_TAKE;
      end
      default: begin
        w.jmp    = JMP_ALWAYS;
        w.target = STEP_TAKE;
      end
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/kbf_cfg_regs.sv
// APB register file holding the modifier key codes and the frame type byte.
module kbf_cfg_regs
  import kbf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_LEFT_CTRL:   cfg_nxt.mod_code[0] = cfg_pwdata[7:0];
        REG_LEFT_SHIFT:  cfg_nxt.mod_code[1] = cfg_pwdata[7:0];
        REG_LEFT_ALT:    cfg_nxt.mod_code[2] = cfg_pwdata[7:0];
        REG_RIGHT_CTRL:  cfg_nxt.mod_code[3] = cfg_pwdata[7:0];
        REG_RIGHT_SHIFT: cfg_nxt.mod_code[4] = cfg_pwdata[7:0];
        REG_RIGHT_ALT:   cfg_nxt.mod_code[5] = cfg_pwdata[7:0];
        REG_FRAME_TYPE:  cfg_nxt.frame_type  = cfg_pwdata[7:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LEFT_CTRL:   cfg_prdata = CFG_DW'(cfg_r.mod_code[0]);
      REG_LEFT_SHIFT:  cfg_prdata = CFG_DW'(cfg_r.mod_code[1]);
      REG_LEFT_ALT:    cfg_prdata = CFG_DW'(cfg_r.mod_code[2]);
      REG_RIGHT_CTRL:  cfg_prdata = CFG_DW'(cfg_r.mod_code[3]);
      REG_RIGHT_SHIFT: cfg_prdata = CFG_DW'(cfg_r.mod_code[4]);
      REG_RIGHT_ALT:   cfg_prdata = CFG_DW'(cfg_r.mod_code[5]);
      REG_FRAME_TYPE:  cfg_prdata = CFG_DW'(cfg_r.frame_type);
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MOD_KEYS; i++) begin
        cfg_r.mod_code[i] <= MOD_CODE_RST[i];
      end
      cfg_r.frame_type <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### hw/rtl/kbf_sequencer.sv
// Step counter and control store walk with stalls and conditional jumps.
module kbf_sequencer
  import kbf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t stat,
  output ctl_t  ctl
);

  step_t  step_r;
  step_t  step_nxt;
  ucode_t uw;
  logic   stall;
  logic   jump;

  assign uw        = ucode_rom(step_r);
  assign in_tready = uw.take;
  assign stall     = (uw.take & ~in_tvalid) | (uw.emit & ~stat.out_free);
  assign ctl.uw    = uw;
  assign ctl.go    = ~stall;

  always_comb begin
    case (uw.jmp)
      JMP_ALWAYS:    jump = 1'b1;
      JMP_SLOT_MORE: jump = ~stat.slot_last;
      default:       jump = 1'b0;
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (!stall) begin
      step_nxt = jump ? uw.target : step_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_TAKE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

### hw/rtl/kbf_datapath.sv
// Modifier byte, held key list, checksum and frame byte output register.
module kbf_datapath
  import kbf_pkg::*;
#(
  parameter int MAX_KEYS  = MAX_KEYS_DEF,
  parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  ctl_t       ctl,
  output stat_t      stat,
  input  logic [7:0] in_tdata,
  input  logic       in_tuser,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  localparam int CNT_W  = $clog2(MAX_KEYS + 1);
  localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam logic [7:0] LEN_BYTE = 8'(1 + KEY_SLOTS);

  logic [7:0]       mod_r,   mod_nxt;
  logic [7:0]       held_r   [MAX_KEYS];
  logic [7:0]       held_nxt [MAX_KEYS];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [7:0]       sum_r,   sum_nxt;
  logic [7:0]       out_data_r;
  logic             out_last_r;
  logic             out_valid_r;

  logic             take;
  logic             emit;
  logic             is_mod;
  logic [7:0]       mod_mask;
  logic [MAX_KEYS-1:0] hit;
  logic             found;
  logic [7:0]       key_byte;
  logic [7:0]       byte_sel;
  logic [7:0]       weighted;

  assign take = ctl.go & ctl.uw.take;
  assign emit = ctl.go & ctl.uw.emit;

  assign stat.out_free  = ~out_valid_r | out_tready;
  assign stat.slot_last = (slot_r == SLOT_W'(KEY_SLOTS - 1));

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    is_mod   = 1'b0;
    mod_mask = '0;
    for (int i = 0; i < MOD_KEYS; i++) begin
      if (cfg.mod_code[i] == in_tdata) begin
        is_mod   = 1'b1;
        mod_mask = 8'(1) << MOD_BIT[i];
      end
    end
  end

  always_comb begin
    hit = '0;
    for (int j = 0; j < MAX_KEYS; j++) begin
      hit[j] = (j < int'(count_r)) && (held_r[j] == in_tdata);
      if (j > 0) begin
        hit[j] = hit[j] | hit[j-1];
      end
    end
    found = hit[MAX_KEYS-1];
  end

  always_comb begin
    key_byte = '0;
    for (int j = 0; j < MAX_KEYS; j++) begin
      if ((j < int'(count_r)) && (int'(slot_r) == j)) begin
        key_byte = held_r[j];
      end
    end
  end

  always_comb begin
    case (ctl.uw.src)
      SRC_SOH:  byte_sel = BYTE_SOH;
      SRC_STX:  byte_sel = BYTE_STX;
      SRC_TYPE: byte_sel = cfg.frame_type;
      SRC_LEN:  byte_sel = LEN_BYTE;
      SRC_MOD:  byte_sel = mod_r;
      SRC_KEY:  byte_sel = key_byte;
      SRC_SUM:  byte_sel = sum_r;
      SRC_ETX:  byte_sel = BYTE_ETX;
      SRC_EOT:  byte_sel = BYTE_EOT;
      default:  byte_sel = '0;
    endcase
  end

  assign weighted = 8'(16'(byte_sel) * 16'(SUM_WEIGHT));

  always_comb begin
    mod_nxt   = mod_r;
    count_nxt = count_r;
    for (int j = 0; j < MAX_KEYS; j++) begin
      held_nxt[j] = held_r[j];
    end
    if (take) begin
      if (is_mod) begin
        mod_nxt = in_tuser ? (mod_r | mod_mask) : (mod_r & ~mod_mask);
      end else if (in_tuser) begin
        if (int'(count_r) < MAX_KEYS) begin
          for (int j = 0; j < MAX_KEYS; j++) begin
            if (int'(count_r) == j) begin
              held_nxt[j] = in_tdata;
            end
          end
          count_nxt = count_r + CNT_W'(1);
        end
      end else if (found) begin
        // close up behind the first matching entry
        for (int j = 0; j < MAX_KEYS - 1; j++) begin
          if (hit[j]) begin
            held_nxt[j] = held_r[j+1];
          end
        end
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_comb begin
    slot_nxt = slot_r;
    sum_nxt  = sum_r;
    if (take) begin
      slot_nxt = '0;
    end else if (emit) begin
      if (ctl.uw.slot_inc && !stat.slot_last) begin
        slot_nxt = slot_r + SLOT_W'(1);
      end
      case (ctl.uw.sum_op)
        SUM_INIT: sum_nxt = weighted;
        SUM_ADD:  sum_nxt = sum_r + weighted;
        default:  sum_nxt = sum_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r       <= '0;
      count_r     <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mod_r   <= mod_nxt;
      count_r <= count_nxt;
      slot_r  <= slot_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_KEYS; j++) begin
      held_r[j] <= held_nxt[j];
    end
    sum_r <= sum_nxt;
    if (emit) begin
      out_data_r <= byte_sel;
      out_last_r <= ctl.uw.last;
    end
  end

endmodule

### hw/rtl/keyboard_report_framer_core.sv
// Top level of the keyboard report framer: key events in, framed report bytes out.
//
// in_*  : one word per key event; in_tdata is the key code, in_tuser is 1 for a press.
// out_* : one word per frame byte; out_tlast marks the closing EOT byte.
// cfg_* : APB register port; modifier key codes at 0x00-0x14, frame type at 0x18.
//
// Each accepted event updates the modifier byte and the held key list, then
// produces a frame of KEY_SLOTS + 8 bytes: SOH, STX, type, length, modifier,
// KEY_SLOTS key bytes, checksum, ETX, EOT.
// One control store step accepts and applies the event, then one step per
// byte follows. After acceptance the sequencer moves to the SOH step, which
// loads the first byte into the output register; the key slot loop of
// the sequencer sets the frame length and so the event rate.
// A stalled out_tready holds the sequencer on its current byte step; the
// output register keeps its word until taken. No new event is taken before
// the previous frame's last byte has been loaded.
// Reset clears the modifier byte, the key count and the sequencer, and
// restores the default modifier codes and a frame type of zero.
module keyboard_report_framer_core
  import kbf_pkg::*;
#(
  parameter int MAX_KEYS  = MAX_KEYS_DEF,
  parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,     // [7:0] key_code
  input  logic              in_tuser,     // [0] is_press
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,    // [7:0] frame_byte
  output logic              out_tlast,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t  cfg;
  ctl_t  ctl;
  stat_t stat;

  kbf_cfg_regs u_cfg_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  kbf_sequencer u_sequencer (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctl       (ctl)
  );

  kbf_datapath #(
    .MAX_KEYS  (MAX_KEYS),
    .KEY_SLOTS (KEY_SLOTS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .ctl        (ctl),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### test/keyboard_report_framer_core_test.sv
// Self-checking stream testbench for the keyboard report framer core.
module keyboard_report_framer_core_test;
  import kbf_pkg::*;

  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_EVENTS  = 60;
  localparam int PHASE_COUNT   = 6;
  localparam int ROW_COUNT     = 24;

  typedef logic [0:KEY_SLOTS_DEF-1][7:0] slot_bytes_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_word_t;

  typedef struct packed {
    logic [7:0]  key;
    logic        press;
    logic        typed;
    logic [7:0]  mods;
    slot_bytes_t slots;
  } key_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [7:0]        in_tdata;     // [7:0] key_code
  logic              in_tuser;     // [0] is_press
  logic              out_tvalid;
  logic              out_tready;
  logic [7:0]        out_tdata;    // [7:0] frame_byte
  logic              out_tlast;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // shadow of the block's registers and keyboard state
  logic [7:0]  mod_code [MOD_KEYS];
  logic [7:0]  report_type;
  logic [7:0]  modifier_byte;
  logic [7:0]  held_slot [MAX_KEYS_DEF];
  int          held_n;

  frame_word_t frame_bytes_due [$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  bit          typed_row = 1'b0;
  logic [7:0]  typed_mods;
  slot_bytes_t typed_slots;

  int          ready_style = 0;
  int          style_left = 0;
  int          stall_left = 0;

  keyboard_report_framer_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic key_row_t ev(input logic [7:0] key, input logic press,
                                  input logic typed, input logic [7:0] mods,
                                  input slot_bytes_t slots);
    return {key, press, typed, mods, slots};
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic void apply_key_event(input logic [7:0] key, input logic press);
    int         hit;
    int         i;
    logic [7:0] mask;
    hit = -1;
    // the highest matching register wins
    for (i = 0; i < MOD_KEYS; i++)
      if (mod_code[i] == key) hit = i;
    if (hit >= 0) begin
      case (reg_idx_t'(3'(hit)))
        REG_LEFT_CTRL:   mask = 8'h01;
        REG_LEFT_SHIFT:  mask = 8'h02;
        REG_LEFT_ALT:    mask = 8'h04;
        REG_RIGHT_CTRL:  mask = 8'h10;
        REG_RIGHT_SHIFT: mask = 8'h20;
        default:         mask = 8'h40;
      endcase
      modifier_byte = press ? (modifier_byte | mask) : (modifier_byte & ~mask);
    end else if (press) begin
      if (held_n < MAX_KEYS_DEF) begin
        held_slot[held_n] = key;
        held_n++;
      end
    end else begin
      hit = -1;
      for (i = 0; i < held_n; i++)
        if (hit < 0 && held_slot[i] == key) hit = i;
      if (hit >= 0) begin
        for (i = hit; i < held_n - 1; i++) held_slot[i] = held_slot[i + 1];
        held_n--;
      end
    end
  endfunction

  function automatic void queue_frame(input logic [7:0] mods, input slot_bytes_t slots);
    logic [7:0] sum;
    int         i;
    sum = mods * SUM_WEIGHT;
    frame_bytes_due.push_back({BYTE_SOH, 1'b0});
    frame_bytes_due.push_back({BYTE_STX, 1'b0});
    frame_bytes_due.push_back({report_type, 1'b0});
    frame_bytes_due.push_back({8'(KEY_SLOTS_DEF + 1), 1'b0});
    frame_bytes_due.push_back({mods, 1'b0});
    for (i = 0; i < KEY_SLOTS_DEF; i++) begin
      sum = sum + slots[i] * SUM_WEIGHT;
      frame_bytes_due.push_back({slots[i], 1'b0});
    end
    frame_bytes_due.push_back({sum, 1'b0});
    frame_bytes_due.push_back({BYTE_ETX, 1'b0});
    frame_bytes_due.push_back({BYTE_EOT, 1'b1});
  endfunction

  always @(posedge clk) begin
    frame_word_t due;
    slot_bytes_t slots;
    int          i;
    if (!rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (in_tvalid && in_tready) begin
        idle_cycles = 0;
        apply_key_event(in_tdata, in_tuser);
        slots = '0;
        for (i = 0; i < held_n; i++) slots[i] = held_slot[i];
        if (typed_row) queue_frame(typed_mods, typed_slots);
        else queue_frame(modifier_byte, slots);
      end
      if (out_tvalid && out_tready) begin
        idle_cycles = 0;
        if (frame_bytes_due.size() == 0) begin
          report_mismatch($sformatf("word %h with nothing outstanding", out_tdata));
        end else begin
          due = frame_bytes_due.pop_front();
          if (out_tdata !== due.data)
            report_mismatch($sformatf("frame_byte %h, want %h", out_tdata, due.data));
          if (out_tlast !== due.last)
            report_mismatch($sformatf("last_byte %b, want %b", out_tlast, due.last));
        end
      end
    end
  end

  // receiver: switch between always ready, random stalls and long holds
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      case (ready_style)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(3, 0) != 0);
        2: out_tready <= ($urandom_range(3, 0) == 0);
        default: begin
          out_tready <= 1'b1;
          if ($urandom_range(15, 0) == 0) stall_left <= $urandom_range(30, 1);
        end
      endcase
    end
    if (style_left == 0) begin
      ready_style <= $urandom_range(3, 0);
      style_left  <= $urandom_range(300, 50);
    end else begin
      style_left <= style_left - 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(negedge clk);
    $display("Verification failed");
    $finish;
  end

  task automatic offer_event(input logic [7:0] key, input logic press);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(12, 0);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(4, 0) == 0) ? 40 : $urandom_range(8, 1);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= key;
    in_tuser  <= press;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold off until every frame byte has been taken
  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [7:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= CFG_DW'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_FRAME_TYPE: report_type = value;
      REG_NONE:       ;
      default:        mod_code[idx] = value;
    endcase
    @(negedge clk);
  endtask

  initial begin
    key_row_t   key_rows [ROW_COUNT];
    logic [7:0] phase_codes [MOD_KEYS];
    logic [7:0] phase_type;
    logic [7:0] key;
    logic       press;
    int         phase;
    int         r;
    int         n;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;

    mod_code[REG_LEFT_CTRL]   = 8'd224;
    mod_code[REG_LEFT_SHIFT]  = 8'd225;
    mod_code[REG_LEFT_ALT]    = 8'd226;
    mod_code[REG_RIGHT_CTRL]  = 8'd228;
    mod_code[REG_RIGHT_SHIFT] = 8'd229;
    mod_code[REG_RIGHT_ALT]   = 8'd230;
    report_type   = 8'h00;
    modifier_byte = 8'h00;
    held_n        = 0;

    key_rows = '{
      ev(8'h00,  1'b0, 1'b1, 8'h00, 56'h00000000000000),
      ev(8'd224, 1'b1, 1'b1, 8'h01, 56'h00000000000000),
      ev(8'd230, 1'b1, 1'b1, 8'h41, 56'h00000000000000),
      ev(8'h04,  1'b1, 1'b1, 8'h41, 56'h04000000000000),
      ev(8'h04,  1'b1, 1'b1, 8'h41, 56'h04040000000000),
      ev(8'hFF,  1'b1, 1'b1, 8'h41, 56'h0404FF00000000),
      ev(8'h00,  1'b1, 1'b1, 8'h41, 56'h0404FF00000000),
      ev(8'd227, 1'b1, 1'b1, 8'h41, 56'h0404FF00E30000),
      ev(8'h7F,  1'b1, 1'b1, 8'h41, 56'h0404FF00E37F00),
      ev(8'h80,  1'b1, 1'b1, 8'h41, 56'h0404FF00E37F00),
      ev(8'h04,  1'b0, 1'b1, 8'h41, 56'h04FF00E37F0000),
      ev(8'h55,  1'b0, 1'b1, 8'h41, 56'h04FF00E37F0000),
      ev(8'd225, 1'b0, 1'b1, 8'h41, 56'h04FF00E37F0000),
      ev(8'd225, 1'b1, 1'b1, 8'h43, 56'h04FF00E37F0000),
      ev(8'd226, 1'b1, 1'b1, 8'h47, 56'h04FF00E37F0000),
      ev(8'd228, 1'b1, 1'b1, 8'h57, 56'h04FF00E37F0000),
      ev(8'd229, 1'b1, 1'b1, 8'h77, 56'h04FF00E37F0000),
      ev(8'd231, 1'b1, 1'b1, 8'h77, 56'h04FF00E37FE700),
      ev(8'd224, 1'b0, 1'b1, 8'h76, 56'h04FF00E37FE700),
      ev(8'd230, 1'b0, 1'b1, 8'h36, 56'h04FF00E37FE700),
      ev(8'h7F,  1'b0, 1'b0, 8'h00, 56'h00000000000000),
      ev(8'hFF,  1'b0, 1'b0, 8'h00, 56'h00000000000000),
      ev(8'h04,  1'b0, 1'b0, 8'h00, 56'h00000000000000),
      ev(8'h00,  1'b0, 1'b0, 8'h00, 56'h00000000000000)
    };

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (n = 0; n < ROW_COUNT; n++) begin
      typed_row   = key_rows[n].typed;
      typed_mods  = key_rows[n].mods;
      typed_slots = key_rows[n].slots;
      offer_event(key_rows[n].key, key_rows[n].press);
    end
    typed_row = 1'b0;

    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      settle_block();
      case (phase)
        1: begin
          foreach (phase_codes[r]) phase_codes[r] = 8'h00;
          phase_type = 8'h00;
        end
        2: begin
          foreach (phase_codes[r]) phase_codes[r] = 8'hFF;
          phase_type = 8'hFF;
        end
        3: begin
          foreach (phase_codes[r]) phase_codes[r] = 8'h3A;
          phase_type = 8'h5A;
        end
        4: begin
          foreach (phase_codes[r]) phase_codes[r] = 8'($urandom_range(255, 0));
          phase_codes[REG_RIGHT_SHIFT] = phase_codes[REG_LEFT_ALT];
          phase_codes[REG_RIGHT_ALT]   = phase_codes[REG_LEFT_CTRL];
          phase_type = 8'($urandom_range(255, 0));
        end
        default: begin
          phase_codes[REG_LEFT_CTRL]   = 8'd224;
          phase_codes[REG_LEFT_SHIFT]  = 8'd225;
          phase_codes[REG_LEFT_ALT]    = 8'd226;
          phase_codes[REG_RIGHT_CTRL]  = 8'd228;
          phase_codes[REG_RIGHT_SHIFT] = 8'd229;
          phase_codes[REG_RIGHT_ALT]   = 8'd230;
          phase_type = 8'h01;
        end
      endcase
      if (phase != 0) begin
        for (r = 0; r < MOD_KEYS; r++) write_register(reg_idx_t'(3'(r)), phase_codes[r]);
        write_register(REG_FRAME_TYPE, phase_type);
        if (phase == 1) write_register(REG_NONE, 8'hA5);
      end

      repeat (PHASE_EVENTS) begin
        r     = $urandom_range(99, 0);
        press = 1'($urandom_range(1, 0));
        if (r < 30) begin
          key = mod_code[$urandom_range(MOD_KEYS - 1, 0)];
        end else if (r < 55 && held_n != 0) begin
          key   = held_slot[$urandom_range(held_n - 1, 0)];
          press = ($urandom_range(4, 0) == 0);
        end else if (r < 90) begin
          key   = 8'($urandom_range(11, 0) + 4);
          press = (held_n < MAX_KEYS_DEF) ? ($urandom_range(3, 0) != 0)
                                          : ($urandom_range(3, 0) == 0);
        end else begin
          key = 8'($urandom_range(255, 0));
        end
        offer_event(key, press);
        if ($urandom_range(39, 0) == 0) settle_block();
      end
    end

    settle_block();
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
